### sv/channel_credit_timing_model_defines.svh
`ifndef CHANNEL_CREDIT_TIMING_MODEL_DEFINES_SVH
`define CHANNEL_CREDIT_TIMING_MODEL_DEFINES_SVH

// same-cycle implication check
`define CCTM_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cctm check failed");

// next-cycle implication check
`define CCTM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cctm check failed");

`endif

### sv/cctm_pkg.sv
`timescale 1ns / 1ps
package cctm_pkg;

    localparam int SLOTS            = 1024;
    localparam int SLOT_NS          = 1024;
    localparam int UNIT_BYTES       = 4096;
    localparam int CREDITS_PER_UNIT = 1;

    localparam int TIME_W    = 64;
    localparam int LEN_W     = 25;
    localparam int CRED_W    = 16;
    localparam int UTT_W     = 20;
    localparam int SLOT_BITS = $clog2(SLOTS);
    localparam int SPAN_W    = SLOT_BITS + 1;
    localparam int SLOT_SH   = $clog2(SLOT_NS);
    localparam int TSLOT_W   = TIME_W - SLOT_SH;
    localparam int UNIT_SH   = $clog2(UNIT_BYTES);
    localparam int UNITS_W   = LEN_W - UNIT_SH + 1;
    localparam int CPU_W     = $clog2(CREDITS_PER_UNIT + 1);
    localparam int NEED_W    = ((UNITS_W + CPU_W) > CRED_W) ? (UNITS_W + CPU_W + 1) : (CRED_W + 1);
    localparam int DCNT_W    = $clog2(NEED_W + 1);
    localparam int PROD_W    = UTT_W + UNITS_W;

    localparam logic [CRED_W-1:0] RESET_CREDITS = CRED_W'(1);

    localparam logic [1:0] REG_SLOT_CREDITS = 2'd0;
    localparam logic [1:0] REG_UNIT_TIME    = 2'd1;
    localparam logic [1:0] REG_OVERHEAD     = 2'd2;

    typedef struct packed {
        logic [TIME_W-1:0] present_time;
        logic [TIME_W-1:0] start_time;
        logic [LEN_W-1:0]  byte_length;
    } in_item_t;

    typedef struct packed {
        logic [TIME_W-1:0] completion_time;
        logic              ring_exhausted;
    } out_item_t;

    typedef struct packed {
        logic [CRED_W-1:0] slot_credits;
        logic [UTT_W-1:0]  unit_transfer_time;
        logic [CRED_W-1:0] command_overhead_credits;
    } cfg_t;

    // classified request passed from front to back
    typedef struct packed {
        logic [TIME_W-1:0]    start_time;
        logic [TSLOT_W-1:0]   now_slot;
        logic                 late;
        logic [SLOT_BITS-1:0] roff;
        logic [UNITS_W-1:0]   units;
        logic [NEED_W-1:0]    need;
    } req_t;

    typedef struct packed {
        logic              clearing;
        logic [SPAN_W-1:0] span;
    } back_status_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REFILL,
        ST_SETUP,
        ST_DIV,
        ST_READ,
        ST_CHECK,
        ST_MUL,
        ST_SUM
    } back_state_t;

endpackage

### sv/cctm_front.sv
`timescale 1ns / 1ps
module cctm_front (
    input  cctm_pkg::in_item_t item,
    input  cctm_pkg::cfg_t     cfg,
    output cctm_pkg::req_t     req
);

    logic [cctm_pkg::TSLOT_W-1:0]   start_slot;
    logic [cctm_pkg::TSLOT_W-1:0]   roff_full;
    logic [cctm_pkg::LEN_W:0]       len_up;
    logic [cctm_pkg::UNITS_W-1:0]   units;

    always_comb
    begin
        start_slot = item.start_time[cctm_pkg::TIME_W-1:cctm_pkg::SLOT_SH];
        req.now_slot = item.present_time[cctm_pkg::TIME_W-1:cctm_pkg::SLOT_SH];
        req.start_time = item.start_time;
        req.late = item.start_time < item.present_time;
        roff_full = start_slot - req.now_slot;
        // far start saturates to the last slot of the ring
        if (roff_full >= cctm_pkg::TSLOT_W'(cctm_pkg::SLOTS))
            req.roff = cctm_pkg::SLOT_BITS'(cctm_pkg::SLOTS - 1);
        else
            req.roff = roff_full[cctm_pkg::SLOT_BITS-1:0];
        len_up = {1'b0, item.byte_length} + (cctm_pkg::LEN_W + 1)'(cctm_pkg::UNIT_BYTES - 1);
        units = len_up[cctm_pkg::LEN_W:cctm_pkg::UNIT_SH];
        req.units = units;
        req.need = cctm_pkg::NEED_W'(units) * cctm_pkg::NEED_W'(cctm_pkg::CREDITS_PER_UNIT)
                 + cctm_pkg::NEED_W'(cfg.command_overhead_credits);
    end

endmodule

### sv/cctm_queue.sv
`timescale 1ns / 1ps
module cctm_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  cctm_pkg::req_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output cctm_pkg::req_t pop_data
);

    cctm_pkg::req_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;

    assign full      = count_reg == 2'd2;
    assign not_empty = count_reg != 2'd0;
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

### sv/cctm_back.sv
`timescale 1ns / 1ps
module cctm_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  cctm_pkg::cfg_t          cfg,
    input  logic                    req_valid,
    input  cctm_pkg::req_t          req,
    output logic                    req_pop,
    output logic                    out_valid,
    input  logic                    out_stall,
    output cctm_pkg::out_item_t     out_data,
    output cctm_pkg::back_status_t  status
);

    localparam int SB = cctm_pkg::SLOT_BITS;

    logic [cctm_pkg::CRED_W-1:0] mem [cctm_pkg::SLOTS];
    logic [cctm_pkg::CRED_W-1:0] rdata_reg;

    cctm_pkg::back_state_t         state_reg, state_next;
    cctm_pkg::req_t                item_reg, item_next;
    logic [SB-1:0]                 head_reg, head_next;
    logic [cctm_pkg::TSLOT_W-1:0]  last_slot_reg, last_slot_next;
    logic [cctm_pkg::SPAN_W-1:0]   span_reg, span_next;
    logic [cctm_pkg::SPAN_W-1:0]   cnt_reg, cnt_next;
    logic [SB-1:0]                 pos_reg, pos_next;
    logic [cctm_pkg::NEED_W-1:0]   need_reg, need_next;
    logic [SB-1:0]                 steps_reg, steps_next;
    logic                          exh_reg, exh_next;
    logic [cctm_pkg::NEED_W-1:0]   quot_reg, quot_next;
    logic [cctm_pkg::CRED_W:0]     rem_reg, rem_next;
    logic [cctm_pkg::DCNT_W-1:0]   dcnt_reg, dcnt_next;
    logic [cctm_pkg::PROD_W-1:0]   prod_reg, prod_next;
    logic [SB-1:0]                 spare_reg, spare_next;
    logic                          out_valid_reg, out_valid_next;
    cctm_pkg::out_item_t           out_reg, out_next;

    logic                          mem_we;
    logic [SB-1:0]                 mem_waddr;
    logic [cctm_pkg::CRED_W-1:0]   mem_wdata;
    logic [SB-1:0]                 mem_raddr;

    logic [cctm_pkg::TSLOT_W-1:0]  adv_full;
    logic [cctm_pkg::SPAN_W-1:0]   adv;
    logic [cctm_pkg::CRED_W-1:0]   divisor;
    logic [cctm_pkg::CRED_W:0]     rem_sh;
    logic [cctm_pkg::NEED_W-1:0]   take;
    logic [cctm_pkg::NEED_W-1:0]   need_left;
    logic [SB-1:0]                 nxt;
    logic [cctm_pkg::SPAN_W-1:0]   span_new;
    logic                          out_free;

    assign out_valid       = out_valid_reg;
    assign out_data        = out_reg;
    assign status.clearing = state_reg == cctm_pkg::ST_CLEAR;
    assign status.span     = span_reg;
    assign out_free        = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        head_next      = head_reg;
        last_slot_next = last_slot_reg;
        span_next      = span_reg;
        cnt_next       = cnt_reg;
        pos_next       = pos_reg;
        need_next      = need_reg;
        steps_next     = steps_reg;
        exh_next       = exh_reg;
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        dcnt_next      = dcnt_reg;
        prod_next      = prod_reg;
        spare_next     = spare_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        req_pop        = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = head_reg;
        mem_wdata      = cfg.slot_credits;
        mem_raddr      = pos_reg;
        divisor        = (cfg.slot_credits != '0) ? cfg.slot_credits : cctm_pkg::CRED_W'(1);
        rem_sh         = {rem_reg[cctm_pkg::CRED_W-1:0], quot_reg[cctm_pkg::NEED_W-1]};
        take           = (need_reg <= cctm_pkg::NEED_W'(rdata_reg))
                         ? need_reg : cctm_pkg::NEED_W'(rdata_reg);
        need_left      = need_reg - take;
        nxt            = pos_reg + SB'(1);
        span_new       = cctm_pkg::SPAN_W'(SB'(pos_reg - head_reg)) + cctm_pkg::SPAN_W'(1);

        // slot difference wraps when time runs backwards, then clamps to the span
        adv_full = req.now_slot - last_slot_reg;
        if (req.now_slot < last_slot_reg || adv_full > cctm_pkg::TSLOT_W'(span_reg))
            adv = span_reg;
        else
            adv = adv_full[cctm_pkg::SPAN_W-1:0];

        case (state_reg)
            cctm_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg[SB-1:0];
                mem_wdata = cctm_pkg::RESET_CREDITS;
                cnt_next  = cnt_reg + cctm_pkg::SPAN_W'(1);
                if (cnt_reg == cctm_pkg::SPAN_W'(cctm_pkg::SLOTS - 1))
                    state_next = cctm_pkg::ST_IDLE;
            end
            cctm_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_pop        = 1'b1;
                    item_next      = req;
                    last_slot_next = req.now_slot;
                    cnt_next       = adv;
                    state_next     = cctm_pkg::ST_REFILL;
                end
            end
            cctm_pkg::ST_REFILL:
            begin
                if (cnt_reg == '0)
                begin
                    pos_next = head_reg + item_reg.roff;
                    if (item_reg.late)
                    begin
                        if (out_free)
                        begin
                            out_next.completion_time = item_reg.start_time;
                            out_next.ring_exhausted  = 1'b0;
                            out_valid_next = 1'b1;
                            state_next     = cctm_pkg::ST_IDLE;
                        end
                    end
                    else
                        state_next = cctm_pkg::ST_SETUP;
                end
                else
                begin
                    mem_we    = 1'b1;
                    head_next = head_reg + SB'(1);
                    span_next = span_reg - cctm_pkg::SPAN_W'(1);
                    cnt_next  = cnt_reg - cctm_pkg::SPAN_W'(1);
                end
            end
            cctm_pkg::ST_SETUP:
            begin
                quot_next  = item_reg.need;
                rem_next   = '0;
                dcnt_next  = cctm_pkg::DCNT_W'(cctm_pkg::NEED_W);
                need_next  = item_reg.need;
                steps_next = '0;
                exh_next   = 1'b0;
                state_next = cctm_pkg::ST_DIV;
            end
            cctm_pkg::ST_DIV:
            begin
                // restoring divide, one quotient bit a cycle
                if (rem_sh >= {1'b0, divisor})
                begin
                    rem_next  = rem_sh - {1'b0, divisor};
                    quot_next = {quot_reg[cctm_pkg::NEED_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh;
                    quot_next = {quot_reg[cctm_pkg::NEED_W-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg - cctm_pkg::DCNT_W'(1);
                if (dcnt_reg == cctm_pkg::DCNT_W'(1))
                    state_next = cctm_pkg::ST_READ;
            end
            cctm_pkg::ST_READ:
            begin
                state_next = cctm_pkg::ST_CHECK;
            end
            cctm_pkg::ST_CHECK:
            begin
                mem_we    = 1'b1;
                mem_waddr = pos_reg;
                mem_wdata = rdata_reg - take[cctm_pkg::CRED_W-1:0];
                need_next = need_left;
                if (need_left == '0 || nxt == head_reg)
                begin
                    exh_next = need_left != '0;
                    if (span_new > span_reg)
                        span_next = span_new;
                    state_next = cctm_pkg::ST_MUL;
                end
                else
                begin
                    steps_next = steps_reg + SB'(1);
                    pos_next   = nxt;
                    state_next = cctm_pkg::ST_READ;
                end
            end
            cctm_pkg::ST_MUL:
            begin
                prod_next = cctm_pkg::PROD_W'(cfg.unit_transfer_time)
                          * cctm_pkg::PROD_W'(item_reg.units);
                if (cctm_pkg::NEED_W'(steps_reg) > quot_reg)
                    spare_next = steps_reg - quot_reg[SB-1:0];
                else
                    spare_next = '0;
                state_next = cctm_pkg::ST_SUM;
            end
            cctm_pkg::ST_SUM:
            begin
                if (out_free)
                begin
                    out_next.completion_time = item_reg.start_time
                        + cctm_pkg::TIME_W'(prod_reg)
                        + (cctm_pkg::TIME_W'(spare_reg) << cctm_pkg::SLOT_SH);
                    out_next.ring_exhausted = exh_reg;
                    out_valid_next = 1'b1;
                    state_next     = cctm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cctm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cctm_pkg::ST_CLEAR;
            head_reg      <= '0;
            last_slot_reg <= '0;
            span_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            last_slot_reg <= last_slot_next;
            span_reg      <= span_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        pos_reg   <= pos_next;
        need_reg  <= need_next;
        steps_reg <= steps_next;
        exh_reg   <= exh_next;
        quot_reg  <= quot_next;
        rem_reg   <= rem_next;
        dcnt_reg  <= dcnt_next;
        prod_reg  <= prod_next;
        spare_reg <= spare_next;
        out_reg   <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rdata_reg <= mem[mem_raddr];
    end

endmodule

### sv/channel_credit_timing_model.sv
`timescale 1ns / 1ps
// Credit timing model of a bandwidth-limited channel. After reset the slot
// store is filled, during which in_stall stays high. Each item then refills
// adv slots, one slot refilled per cycle, runs a bit-serial credit divider,
// and visits each slot in a read state and then a check state, set by the
// single read port of the slot store. A late request skips the divide and
// walk. A two-entry queue lets new items in while the back end works.
`include "channel_credit_timing_model_defines.svh"
module channel_credit_timing_model (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  cctm_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output cctm_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [19:0]         cfg_data
);

    cctm_pkg::cfg_t         cfg_reg;
    cctm_pkg::cfg_t         cfg_next;
    cctm_pkg::req_t         front_req;
    cctm_pkg::req_t         q_data;
    cctm_pkg::back_status_t status;
    logic                   q_full;
    logic                   q_valid;
    logic                   q_pop;
    logic                   push;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full || status.clearing;
    assign push      = in_valid && !in_stall;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                cctm_pkg::REG_SLOT_CREDITS: cfg_next.slot_credits = cfg_data[15:0];
                cctm_pkg::REG_UNIT_TIME:    cfg_next.unit_transfer_time = cfg_data;
                cctm_pkg::REG_OVERHEAD:     cfg_next.command_overhead_credits = cfg_data[15:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slot_credits             <= cctm_pkg::RESET_CREDITS;
            cfg_reg.unit_transfer_time       <= '0;
            cfg_reg.command_overhead_credits <= '0;
        end
        else
            cfg_reg <= cfg_next;
    end

    cctm_front u_front (
        .item (in_data),
        .cfg  (cfg_reg),
        .req  (front_req)
    );

    cctm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_req),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_data)
    );

    cctm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .req_valid (q_valid),
        .req       (q_data),
        .req_pop   (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .status    (status)
    );

    `CCTM_ASSERT_IMPL(a_span_bound, 1'b1, status.span <= cctm_pkg::SPAN_W'(cctm_pkg::SLOTS))
    `CCTM_ASSERT_IMPL(a_no_accept_clear, status.clearing, in_stall && !out_valid)
    `CCTM_ASSERT_NEXT(a_pop_needs_item, q_pop, !status.clearing)

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

    localparam int CYCLE_LIMIT = 20_000_000;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    cctm_pkg::in_item_t  in_data = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    cctm_pkg::out_item_t out_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [1:0]          cfg_index = '0;
    logic [19:0]         cfg_data = '0;

    channel_credit_timing_model dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // channel model state
    logic [cctm_pkg::CRED_W-1:0] credit_ring [cctm_pkg::SLOTS];
    int unsigned                 ring_head;
    logic [63:0]                 last_time;
    int unsigned                 live_span;
    logic [cctm_pkg::CRED_W-1:0] full_credits;
    logic [cctm_pkg::UTT_W-1:0]  ns_per_unit;
    logic [cctm_pkg::CRED_W-1:0] overhead;

    cctm_pkg::out_item_t pending_completions[$];
    int          fail_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_left = 0;
    int unsigned cycle_count = 0;
    logic [63:0] time_cursor = '0;

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        fail_count++;
    endtask

    function automatic cctm_pkg::out_item_t predict_completion(input cctm_pkg::in_item_t it);
        logic [63:0] now, start, units, adv, roff, need, take, base, steps, spare, lat;
        int unsigned pos, nxt, span;
        cctm_pkg::out_item_t res;
        now = it.present_time;
        start = it.start_time;
        units = (64'(it.byte_length) + cctm_pkg::UNIT_BYTES - 1) / cctm_pkg::UNIT_BYTES;
        adv = now / cctm_pkg::SLOT_NS - last_time / cctm_pkg::SLOT_NS;
        if (adv > live_span)
            adv = live_span;
        for (int i = 0; i < int'(adv); i++)
            credit_ring[(ring_head + i) % cctm_pkg::SLOTS] = full_credits;
        ring_head = (ring_head + int'(adv)) % cctm_pkg::SLOTS;
        last_time = now;
        live_span -= int'(adv);
        res.ring_exhausted = 1'b0;
        if (start < now)
        begin
            res.completion_time = start;
            return res;
        end
        roff = start / cctm_pkg::SLOT_NS - now / cctm_pkg::SLOT_NS;
        if (roff >= cctm_pkg::SLOTS)
            roff = cctm_pkg::SLOTS - 1;
        pos = (ring_head + int'(roff)) % cctm_pkg::SLOTS;
        need = units * cctm_pkg::CREDITS_PER_UNIT + 64'(overhead);
        base = need / ((full_credits != 0) ? 64'(full_credits) : 64'd1);
        steps = 0;
        forever
        begin
            take = (need <= credit_ring[pos]) ? need : 64'(credit_ring[pos]);
            credit_ring[pos] = credit_ring[pos] - cctm_pkg::CRED_W'(take);
            need -= take;
            if (need == 0)
                break;
            nxt = (pos + 1) % cctm_pkg::SLOTS;
            if (nxt == ring_head)
            begin
                res.ring_exhausted = 1'b1;
                break;
            end
            steps++;
            pos = nxt;
        end
        span = (pos >= ring_head) ? (pos - ring_head + 1)
                                  : (cctm_pkg::SLOTS - (ring_head - pos - 1));
        if (span > live_span)
            live_span = span;
        spare = (steps > base) ? steps - base : 64'd0;
        lat = 64'(ns_per_unit) * units + spare * cctm_pkg::SLOT_NS;
        res.completion_time = start + lat;
        return res;
    endfunction

    task automatic send_request(input logic [63:0] now, input logic [63:0] start,
                                input logic [24:0] len);
        cctm_pkg::in_item_t it;
        it.present_time = now;
        it.start_time = start;
        it.byte_length = len;
        while ($urandom_range(99) < send_idle_pct)
            @(negedge clk);
        in_valid = 1'b1;
        in_data = it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_completions.push_back(predict_completion(it));
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [19:0] val);
        wait (pending_completions.size() == 0);
        repeat (40) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            cctm_pkg::REG_SLOT_CREDITS: full_credits = val[15:0];
            cctm_pkg::REG_UNIT_TIME:    ns_per_unit = val;
            cctm_pkg::REG_OVERHEAD:     overhead = val[15:0];
            default:                    ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_channel(input int sc, input int utt, input int oh);
        write_register(cctm_pkg::REG_SLOT_CREDITS, 20'(sc));
        write_register(cctm_pkg::REG_UNIT_TIME, 20'(utt));
        write_register(cctm_pkg::REG_OVERHEAD, 20'(oh));
    endtask

    // mostly forward-moving time with small requests, plus late, far and wild items
    task automatic send_random_request();
        logic [63:0] now, start;
        logic [24:0] len;
        longint unsigned len_cap;
        int r;
        r = $urandom_range(99);
        if (r < 3)
            now = {$urandom, $urandom};
        else if (r < 6)
            now = time_cursor - 64'($urandom_range(5000));
        else
            now = time_cursor + 64'($urandom_range(8000));
        time_cursor = now;
        r = $urandom_range(99);
        if (r < 10)
            start = now - 64'($urandom_range(3000, 1));
        else if (r < 14)
            start = now + {$urandom_range(255), $urandom};
        else if (r < 16)
            start = {$urandom, $urandom};
        else
            start = now + 64'($urandom_range(30000));
        len_cap = 64'((full_credits != 0) ? full_credits : 1) * 12288;
        if (len_cap > 16777216)
            len_cap = 16777216;
        r = $urandom_range(99);
        if (r < 2)
            len = 25'd16777216;
        else if (r < 4)
            len = 25'($urandom_range(16777216));
        else if (r < 8)
            len = '0;
        else
            len = 25'($urandom_range(int'(len_cap)));
        send_request(now, start, len);
    endtask

    task automatic test_directed();
        send_request(64'd0, 64'd0, 25'd0);
        send_request(64'd0, 64'd5000, 25'd4096);
        send_request(64'd10000, 64'd9999, 25'd100);            // late request
        send_request(64'd20000, 64'd20000 + (64'd1 << 40), 25'd4097); // far start
        send_request(64'd30000, 64'd30000, 25'd16777216);      // ring exhausts
        send_request(64'd1000, 64'd2000, 25'd1);               // time goes backwards
        set_channel(3, 1048575, 0);
        send_request('1, '1, 25'd4096);                        // completion wraps
        send_request('1, 64'd0, 25'd8192);
        send_request(64'd4096, 64'd4096, 25'd12288);
        write_register(cctm_pkg::REG_SLOT_CREDITS, 20'd0);     // slots refill empty
        send_request(64'd5_000_000, 64'd5_000_000, 25'd4096);
        send_request(64'd5_010_000, 64'd5_020_000, 25'd0);
        set_channel(65535, 1048575, 65535);
        send_request(64'd6_000_000, 64'd6_000_000, 25'd16777216);
        send_request(64'd6_100_000, 64'd6_200_000, 25'd0);
        write_register(REG_UNUSED, 20'hFFFFF);                 // ignored write
        send_request(64'd7_000_000, 64'd7_000_000, 25'd40000);
        set_channel(1, 0, 0);
        send_request(64'd8_000_000, 64'd8_000_000, 25'd4096);
        time_cursor = 64'd9_000_000;
    endtask

    task automatic test_random_phase(input int s_pct, input int r_pct, input int sc,
                                     input int utt, input int oh, input int n);
        set_channel(sc, utt, oh);
        send_idle_pct = s_pct;
        recv_stall_pct = r_pct;
        repeat (n) send_random_request();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = 3000;
        repeat (12) send_random_request();
        // then let the channel drain fully before offering more
        wait (pending_completions.size() == 0);
        repeat (4) send_random_request();
    endtask

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall = 1'b1;
            hold_left--;
        end
        else
            out_stall = ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_completions.size() == 0)
                report_mismatch("result with nothing expected");
            else
            begin
                cctm_pkg::out_item_t exp_item;
                exp_item = pending_completions.pop_front();
                if (out_data.completion_time !== exp_item.completion_time)
                    report_mismatch($sformatf("completion_time %h, expected %h",
                        out_data.completion_time, exp_item.completion_time));
                if (out_data.ring_exhausted !== exp_item.ring_exhausted)
                    report_mismatch($sformatf("ring_exhausted %b, expected %b",
                        out_data.ring_exhausted, exp_item.ring_exhausted));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        full_credits = cctm_pkg::RESET_CREDITS;
        ns_per_unit = '0;
        overhead = '0;
        for (int i = 0; i < cctm_pkg::SLOTS; i++)
            credit_ring[i] = cctm_pkg::RESET_CREDITS;
        ring_head = 0;
        last_time = '0;
        live_span = 0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random_phase(0, 0, 8, 100, 3, 360);
        test_random_phase(62, 0, 1, 0, 0, 360);
        test_backpressure();
        test_random_phase(0, 62, 200, 1048575, 1, 360);
        test_random_phase(27, 27, 65535, 5, 0, 360);
        wait (pending_completions.size() == 0);
        repeat (100) @(posedge clk);
        if (pending_completions.size() != 0)
            report_mismatch("expected results left over");
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

### sim.f
+incdir+sv
sv/cctm_pkg.sv
sv/cctm_front.sv
sv/cctm_queue.sv
sv/cctm_back.sv
sv/channel_credit_timing_model.sv
bench/tb_top.sv
